### rtl/sstt_pkg.sv
package sstt_pkg;

	// Pattern geometry
	localparam int CHANNELS      = 8;
	localparam int STEPS         = 16;
	localparam int STEP_W        = $clog2(STEPS);
	localparam int COUNT_W       = STEP_W + 1;

	// Block and crossing limits
	localparam int MAX_BLOCK     = 4096;
	localparam int BLK_W         = 13;
	localparam int MAX_CROSSINGS = 17;
	localparam int K_W           = $clog2(MAX_CROSSINGS + 1);

	// Fixed point: UQ16.12 period and phase
	localparam int FRAC_BITS     = 12;
	localparam int PERIOD_W      = 28;
	localparam int TTF_W         = PERIOD_W + 6;
	localparam int OFFSET_W      = 12;

	// Register file
	localparam int CFG_IDX_W     = 1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(46854144);
	localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_PERIOD = 1'b0,
		REG_STEP_COUNT  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_BLOCK = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

endpackage

### rtl/step_sequencer_trigger_timer_unit.sv
// Step sequencer trigger timer.
// Input channel (in_valid/in_ready) takes one request per audio-side event:
// an audio block (operation, sample_count), start, stop, or a pattern cell
// write (channel, step, active). Output channel (out_valid/out_ready) gives
// one result per step reached: step_index, channel_mask, offset within the
// block, and last on the final result of a request.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// step_period (index 0, UQ16.12 samples per step) and step_count (index 1);
// it is always ready; the user must write it only while the block is idle (not enforced).
// Stop and pattern writes complete in the accept cycle. A start stages
// step 0 and loads it into the output register from the test state. An
// audio block that crosses k step periods (k at most 17) runs the sum
// state, then every crossing runs one subtract/compare pass (step and test
// states) through the shared phase datapath, waiting while the output is held.
// The block takes one request at a time; in_ready is high only when idle.
// When the receiver stalls, the held result stays in the output register
// and the crossing sequencer waits with the next result staged.
// Reset clears the pattern grid, step, phase and run flag, and loads the
// register reset values; no result is pending after reset.
module step_sequencer_trigger_timer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sstt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sstt_pkg::PERIOD_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      operation,
	input  logic [sstt_pkg::BLK_W-1:0]      sample_count,
	input  logic [2:0]                      channel,
	input  logic [3:0]                      step,
	input  logic                            active,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3:0]                      step_index,
	output logic [sstt_pkg::CHANNELS-1:0]   channel_mask,
	output logic [sstt_pkg::OFFSET_W-1:0]   offset,
	output logic                            last
);
	import sstt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_TEST,
		S_STEP
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [PERIOD_W-1:0] period_q;
	logic [COUNT_W-1:0]  count_q;

	// Sequencer state
	logic [CHANNELS-1:0] grid_q [STEPS];
	logic [STEP_W-1:0]   cur_q;
	logic [PERIOD_W-1:0] phase_q;
	logic                running_q;

	// Per-request working registers
	logic signed [TTF_W-1:0] ttf_q;
	logic [BLK_W-1:0]        blk_q;
	logic [K_W-1:0]          k_q;

	// Staged result waiting for the output register
	logic                pend_q;
	logic [STEP_W-1:0]   pend_step_q;
	logic [CHANNELS-1:0] pend_mask_q;
	logic [OFFSET_W-1:0] pend_off_q;

	// Output register
	logic                out_valid_q;
	logic [STEP_W-1:0]   out_step_q;
	logic [CHANNELS-1:0] out_mask_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic                out_last_q;

	logic [PERIOD_W-1:0]     per_eff;
	logic [COUNT_W-1:0]      cnt_eff;
	logic [BLK_W-1:0]        blk_clamp;
	logic [PERIOD_W:0]       phase_sum;
	logic [PERIOD_W-1:0]     phase_sat;
	logic signed [TTF_W-1:0] ttf_init;
	logic                    more;
	logic                    slot_free;
	logic                    load_out;
	logic [STEP_W-1:0]       cur_base;
	logic [COUNT_W-1:0]      cur_inc;
	logic [STEP_W-1:0]       cur_next;
	logic                    ttf_pos;
	logic [TTF_W-2-FRAC_BITS:0] ttf_smp;
	logic [BLK_W-1:0]        blk_lim;
	logic [OFFSET_W-1:0]     off_calc;
	op_t                     op;

	assign op = op_t'(operation);

	// A zero period behaves as the smallest period.
	assign per_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

	// Clamp the loop length to 1 .. STEPS.
	always_comb begin
		if (count_q == '0) begin
			cnt_eff = COUNT_W'(1);
		end else if (count_q > COUNT_W'(STEPS)) begin
			cnt_eff = COUNT_W'(STEPS);
		end else begin
			cnt_eff = count_q;
		end
	end

	assign blk_clamp = (sample_count > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : sample_count;

	// Add the block length to the phase, saturating at full scale.
	assign phase_sum = (PERIOD_W + 1)'(phase_q)
		+ (PERIOD_W + 1)'({blk_q, {FRAC_BITS{1'b0}}});
	assign phase_sat = phase_sum[PERIOD_W] ? {PERIOD_W{1'b1}} : phase_sum[PERIOD_W-1:0];

	// Distance from block start to the first crossing, before the add.
	assign ttf_init = signed'(TTF_W'(per_eff) - TTF_W'(phase_q));

	// Another crossing is due while the phase holds a full period and fewer than MAX_CROSSINGS have run.
	assign more = (phase_q >= per_eff) && (k_q != K_W'(MAX_CROSSINGS));

	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = (state_q == S_TEST) && pend_q && slot_free;

	// Advance the step, wrapping at the loop length; an out-of-loop step counts as 0 before the advance.
	assign cur_base = (COUNT_W'(cur_q) >= cnt_eff) ? '0 : cur_q;
	assign cur_inc  = COUNT_W'(cur_base) + COUNT_W'(1);
	assign cur_next = (cur_inc == cnt_eff) ? '0 : cur_inc[STEP_W-1:0];

	// Offset of this crossing in whole samples, clamped to the block.
	assign ttf_pos = !ttf_q[TTF_W-1] && (ttf_q != '0);
	assign ttf_smp = ttf_q[TTF_W-2:FRAC_BITS];
	assign blk_lim = blk_q - BLK_W'(1);

	always_comb begin
		if (!ttf_pos || (blk_q == '0)) begin
			off_calc = '0;
		end else if (ttf_smp > (TTF_W - 1 - FRAC_BITS)'(blk_lim)) begin
			off_calc = blk_lim[OFFSET_W-1:0];
		end else begin
			off_calc = ttf_smp[OFFSET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= PERIOD_RESET;
			count_q     <= COUNT_RESET;
			grid_q      <= '{default: '0};
			cur_q       <= '0;
			phase_q     <= '0;
			running_q   <= 1'b0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the shown result once it is taken, unless a new one loads.
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_STEP_PERIOD: period_q <= cfg_data;
					REG_STEP_COUNT:  count_q  <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (op)
							OP_START: begin
								// Rewind and stage step 0 at offset 0; the phase
								// of zero ends the crossing test at once.
								cur_q       <= '0;
								phase_q     <= '0;
								running_q   <= 1'b1;
								k_q         <= '0;
								pend_q      <= 1'b1;
								pend_step_q <= '0;
								pend_mask_q <= grid_q[0];
								pend_off_q  <= '0;
								state_q     <= S_TEST;
							end
							OP_STOP: begin
								running_q <= 1'b0;
							end
							OP_WRITE: begin
								if (COUNT_W'(step) < cnt_eff) begin
									grid_q[step][channel] <= active;
								end
							end
							OP_BLOCK: begin
								if (running_q) begin
									blk_q   <= blk_clamp;
									state_q <= S_SUM;
								end
							end
							default: ;
						endcase
					end
				end
				S_SUM: begin
					ttf_q   <= ttf_init;
					phase_q <= phase_sat;
					k_q     <= '0;
					pend_q  <= 1'b0;
					state_q <= S_TEST;
				end
				S_TEST: begin
					// Release the staged result once the output register is
					// free; it is final when no further crossing is due.
					if (pend_q) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							out_step_q  <= pend_step_q;
							out_mask_q  <= pend_mask_q;
							out_off_q   <= pend_off_q;
							out_last_q  <= !more;
							pend_q      <= 1'b0;
							state_q     <= more ? S_STEP : S_IDLE;
						end
					end else begin
						state_q <= more ? S_STEP : S_IDLE;
					end
				end
				S_STEP: begin
					phase_q     <= phase_q - per_eff;
					ttf_q       <= ttf_q + signed'(TTF_W'(per_eff));
					cur_q       <= cur_next;
					k_q         <= k_q + K_W'(1);
					pend_q      <= 1'b1;
					pend_step_q <= cur_next;
					pend_mask_q <= grid_q[cur_next];
					pend_off_q  <= off_calc;
					state_q     <= S_TEST;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign step_index   = out_step_q;
	assign channel_mask = out_mask_q;
	assign offset       = out_off_q;
	assign last         = out_last_q;

endmodule

### rtl/sstt_checker.sv
module sstt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [1:0]                      operation,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [3:0]                      step_index,
	input logic [sstt_pkg::CHANNELS-1:0]   channel_mask,
	input logic [sstt_pkg::OFFSET_W-1:0]   offset,
	input logic                            last
);
	import sstt_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(step_index)
			&& $stable(channel_mask) && $stable(offset) && $stable(last))
		else $error("result changed while stalled");

	// A start always produces a result, so the block is busy right after.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_START) |=> !in_ready)
		else $error("start request did not occupy the sequencer");

	// Stop and pattern writes finish in the accept cycle.
	a_ctrl_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ((operation == OP_STOP) || (operation == OP_WRITE))
			|=> in_ready)
		else $error("stop or pattern write left the sequencer busy");

	// While a non-final result is shown, more results of that request follow.
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("idle while a request still has results to give");

	// From an empty output register, a start result reports step 0 at offset 0.
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_START) && !out_valid
			|=> ##1 out_valid && (step_index == 4'd0) && (offset == '0) && last)
		else $error("start result is not step 0 at offset 0");

endmodule

bind step_sequencer_trigger_timer_unit sstt_checker u_sstt_checker (.*);

### verif/step_sequencer_trigger_timer_unit_test.sv
module step_sequencer_trigger_timer_unit_test;
	import sstt_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 12;
	localparam int MAX_GAP         = 12;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int LONG_HOLD       = 400;
	localparam int TAIL_CYCLES     = 50;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam longint PHASE_MAX   = 64'd268435455;

	// One trigger as seen on the output channel
	typedef struct packed {
		logic [3:0]          step_index;
		logic [CHANNELS-1:0] channel_mask;
		logic [OFFSET_W-1:0] offset;
		logic                fin;
	} trigger_t;

	// Tracks sequencer state and the queue of triggers still owed by the block.
	class trigger_scoreboard;
		bit [CHANNELS-1:0] grid [STEPS];
		int                cur_step;
		longint            phase;
		bit                running;
		bit [PERIOD_W-1:0] period;
		bit [COUNT_W-1:0]  count;
		trigger_t          owed_q [$];
		int                mismatches;

		function new();
			foreach (grid[i]) grid[i] = '0;
			cur_step   = 0;
			phase      = 0;
			running    = 1'b0;
			period     = PERIOD_RESET;
			count      = COUNT_RESET;
			mismatches = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [PERIOD_W-1:0] data);
			case (idx)
				REG_STEP_PERIOD: period = data;
				REG_STEP_COUNT:  count  = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int loop_length();
			if (count == 0)
				return 1;
			if (count > STEPS)
				return STEPS;
			return count;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Work out the triggers that one accepted request owes.
		function void note_request(op_t op, logic [BLK_W-1:0] n_in, logic [2:0] ch,
				logic [3:0] st, logic act);
			int       len;
			int       n;
			int       k;
			longint   per;
			longint   ttf;
			longint   s;
			trigger_t t;
			len = loop_length();
			case (op)
				OP_START: begin
					cur_step = 0;
					phase    = 0;
					running  = 1'b1;
					t = '{step_index: 4'd0, channel_mask: grid[0], offset: '0, fin: 1'b1};
					owed_q.push_back(t);
				end
				OP_STOP: running = 1'b0;
				OP_WRITE: begin
					if (st < len)
						grid[st][ch] = act;
				end
				default: begin
					if (running) begin
						n   = (n_in > MAX_BLOCK) ? MAX_BLOCK : n_in;
						per = (period == 0) ? 1 : period;
						ttf = per - phase;
						phase = phase + (longint'(n) << FRAC_BITS);
						if (phase > PHASE_MAX)
							phase = PHASE_MAX;
						k = 0;
						while (phase >= per && k < MAX_CROSSINGS) begin
							phase = phase - per;
							t.offset = '0;
							if (ttf > 0) begin
								s = ttf >> FRAC_BITS;
								if (n == 0)
									t.offset = '0;
								else if (s > n - 1)
									t.offset = OFFSET_W'(n - 1);
								else
									t.offset = OFFSET_W'(s);
							end
							if (cur_step >= len)
								cur_step = 0;
							cur_step = (cur_step + 1) % len;
							t.step_index   = 4'(cur_step);
							t.channel_mask = grid[cur_step];
							// last trigger when the loop will not run again
							t.fin = (phase < per) || (k == MAX_CROSSINGS - 1);
							owed_q.push_back(t);
							k++;
							ttf = ttf + per;
						end
					end
				end
			endcase
		endfunction

		task report(string msg);
			mismatches++;
			$display("ERROR @%0t: %s", $time, msg);
		endtask

		task check_result(logic [3:0] si, logic [CHANNELS-1:0] cm,
				logic [OFFSET_W-1:0] off, logic fin);
			trigger_t t;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected trigger step %0d mask %h offset %0d last %b",
					si, cm, off, fin));
			end else begin
				t = owed_q.pop_front();
				if (si !== t.step_index)
					report($sformatf("step_index got %0d want %0d", si, t.step_index));
				if (cm !== t.channel_mask)
					report($sformatf("channel_mask got %h want %h", cm, t.channel_mask));
				if (off !== t.offset)
					report($sformatf("offset got %0d want %0d", off, t.offset));
				if (fin !== t.fin)
					report($sformatf("last got %b want %b", fin, t.fin));
			end
		endtask

		task close_out();
			while (owed_q.size() != 0) begin
				report($sformatf("trigger never arrived: step %0d", owed_q[0].step_index));
				void'(owed_q.pop_front());
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	reg_idx_t            cfg_index;
	logic [PERIOD_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_ready;
	op_t                 operation;
	logic [BLK_W-1:0]    sample_count;
	logic [2:0]          channel;
	logic [3:0]          step;
	logic                active;
	logic                out_valid;
	logic                out_ready;
	logic [3:0]          step_index;
	logic [CHANNELS-1:0] channel_mask;
	logic [OFFSET_W-1:0] offset;
	logic                last;

	trigger_scoreboard sb;
	bit tx_gaps;
	bit rx_gaps;
	int hold_request;
	int idle_cycles;

	step_sequencer_trigger_timer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sample_count (sample_count),
		.channel      (channel),
		.step         (step),
		.active       (active),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.step_index   (step_index),
		.channel_mask (channel_mask),
		.offset       (offset),
		.last         (last)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Watchdog: end the run once no channel has moved for too long.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("step_sequencer_trigger_timer_unit_test: FAIL");
			$finish;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one request: optionally idle first, then hold valid and payload
	// steady until the block takes it. Returns at the next falling edge.
	task automatic send_request(op_t op, logic [BLK_W-1:0] n, logic [2:0] ch,
			logic [3:0] st, logic act);
		int gap;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation    <= op;
		sample_count <= n;
		channel      <= ch;
		step         <= st;
		active       <= act;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_request(op, n, ch, st, act);
		@(negedge clk);
	endtask

	// Drop valid and hold until every owed trigger is in, then let the
	// block settle in case the last request was a block with no crossing.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both registers back to back; call only while the block is idle.
	task automatic configure(logic [PERIOD_W-1:0] per, logic [PERIOD_W-1:0] cnt);
		cfg_index <= REG_STEP_PERIOD;
		cfg_data  <= per;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_register(REG_STEP_PERIOD, per);
		@(negedge clk);
		cfg_index <= REG_STEP_COUNT;
		cfg_data  <= cnt;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_register(REG_STEP_COUNT, cnt);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return PERIOD_W'(1048576);
			1: return PERIOD_W'(268435455);
			2: return PERIOD_RESET;
			3: return PERIOD_W'($urandom_range(134217728, 268435455));
			4: return PERIOD_W'($urandom_range(1, 1048575));
			default: return PERIOD_W'($urandom_range(1048576, 6291456));
		endcase
	endfunction

	// Step count in the low bits; upper data bits are random half the time.
	function automatic logic [PERIOD_W-1:0] pick_count();
		logic [COUNT_W-1:0] cnt;
		case ($urandom_range(0, 7))
			0: cnt = '0;
			1: cnt = COUNT_W'(1);
			2: cnt = COUNT_W'(16);
			3: cnt = COUNT_W'($urandom_range(17, 31));
			default: cnt = COUNT_W'($urandom_range(2, 15));
		endcase
		if ($urandom_range(0, 1))
			return {(PERIOD_W - COUNT_W)'($urandom()), cnt};
		return PERIOD_W'(cnt);
	endfunction

	// Mostly audio blocks and pattern edits on a running sequencer; starts and
	// stops now and then. A stopped sequencer is usually restarted.
	task automatic random_request();
		int               pick;
		int               sel;
		op_t              op;
		logic [BLK_W-1:0] n;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			op = OP_BLOCK;
		else if (pick < 82)
			op = OP_WRITE;
		else if (pick < 91)
			op = OP_START;
		else
			op = OP_STOP;
		if (!sb.running && op == OP_BLOCK && $urandom_range(0, 3) != 0)
			op = OP_START;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			n = '0;
		else if (sel == 1)
			n = BLK_W'($urandom_range(MAX_BLOCK + 1, 8191));
		else if (sel == 2)
			n = BLK_W'(MAX_BLOCK);
		else
			n = BLK_W'($urandom_range(1, MAX_BLOCK));
		send_request(op, n, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
			1'($urandom_range(0, 1)));
	endtask

	// Result sink: draw a stall before each trigger, or take up a long
	// hold-off when one is asked for, then check what arrives.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result(step_index, channel_mask, offset, last);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [PERIOD_W-1:0] per;
		sb           = new();
		tx_gaps      = 1'b1;
		rx_gaps      = 1'b1;
		hold_request = 0;
		idle_cycles  = 0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_STEP_PERIOD;
		cfg_data     = '0;
		in_valid     = 1'b0;
		operation    = OP_BLOCK;
		sample_count = '0;
		channel      = '0;
		step         = '0;
		active       = 1'b0;
		out_ready    = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Stopped: stop and block requests give nothing.
		send_request(OP_STOP, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(MAX_BLOCK), 3'd5, 4'd9, 1'b1);
		// Paint the pattern: corner and inner cells, then clear and set one corner again.
		send_request(OP_WRITE, '0, 3'd0, 4'd0, 1'b1);
		send_request(OP_WRITE, '0, 3'd7, 4'd15, 1'b1);
		send_request(OP_WRITE, '0, 3'd3, 4'd1, 1'b1);
		send_request(OP_WRITE, '0, 3'd5, 4'd2, 1'b1);
		send_request(OP_WRITE, '0, 3'd7, 4'd15, 1'b0);
		send_request(OP_WRITE, '0, 3'd7, 4'd15, 1'b1);
		// Start at reset tempo; oversized, full, empty and one-sample blocks.
		send_request(OP_START, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, 13'h1FFF, 3'd7, 4'd15, 1'b1);
		send_request(OP_BLOCK, BLK_W'(MAX_BLOCK), 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(MAX_BLOCK), 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(1), 3'd0, 4'd0, 1'b0);

		// Zero period and zero count: crossing cap, leftover crossings fired
		// by an empty block, and a write beyond the loop that is ignored.
		drain();
		configure('0, '0);
		send_request(OP_START, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(MAX_BLOCK), 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_WRITE, '0, 3'd2, 4'd1, 1'b1);
		send_request(OP_WRITE, '0, 3'd2, 4'd0, 1'b1);

		// Walk to step 10, then shrink the loop so the step sits past its end.
		drain();
		configure(PERIOD_W'(1048576), PERIOD_W'(16));
		send_request(OP_START, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(2600), 3'd0, 4'd0, 1'b0);
		drain();
		configure(PERIOD_W'(1048576), {23'h7FFFFF, 5'd4});
		send_request(OP_BLOCK, BLK_W'(300), 3'd0, 4'd0, 1'b0);

		// Longest period with a count above the pattern length.
		drain();
		configure(PERIOD_W'(268435455), PERIOD_W'(31));
		send_request(OP_START, '0, 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(MAX_BLOCK), 3'd0, 4'd0, 1'b0);
		send_request(OP_BLOCK, BLK_W'(MAX_BLOCK), 3'd0, 4'd0, 1'b0);

		// Random phases, each with its own tempo, loop length and idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			per = (ph == 1) ? PERIOD_W'(1048576) : pick_period();
			configure(per, pick_count());
			tx_gaps = $urandom_range(0, 1);
			rx_gaps = $urandom_range(0, 1);
			if (ph == 1) begin
				// Back-pressure: sender keeps offering while the sink holds off.
				tx_gaps = 1'b0;
				hold_request = LONG_HOLD;
				send_request(OP_START, '0, 3'd0, 4'd0, 1'b0);
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				random_request();
		end

		// Wait out owed triggers and any stray output, then judge.
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		sb.close_out();
		if (sb.mismatches == 0) begin
			$display("step_sequencer_trigger_timer_unit_test: PASS");
		end else begin
			$display("step_sequencer_trigger_timer_unit_test: FAIL");
		end
		$finish;
	end

endmodule
